>>> design/rotation_matrix_to_quaternion_macros.svh
// Assertion macros shared by the rotation matrix to quaternion design.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define RMQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence in the same cycle.
`define RMQ_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

`endif

>>> design/rmq_pkg.sv
// Package with the types and constants of the rotation matrix to quaternion design.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
  localparam int MAG_W = 17;
  localparam int Q_W   = 17;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } br_t;

  typedef struct packed {
    br_t                       br;
    logic                      degen;
    logic [2:0]                neg;
    logic [2:0][MAG_W-1:0]     mag;
  } side_t;

  typedef struct packed {
    br_t         br;
    logic        degen;
    logic [2:0]  neg;
    logic [15:0] rootq;
  } post_t;
endpackage
`default_nettype wire

>>> design/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a tag carried alongside.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt #(
  parameter int IN_W  = 32,
  parameter int TAG_W = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                vld_i,
  input  wire logic [IN_W-1:0]     rad_i,
  input  wire logic [TAG_W-1:0]    tag_i,
  output logic                     vld_o,
  output logic [IN_W/2-1:0]        root_o,
  output logic [TAG_W-1:0]         tag_o
);
  localparam int RW = IN_W / 2;

  logic [IN_W-1:0]  rad_r  [RW];
  logic [RW+1:0]    rem_r  [RW];
  logic [RW-1:0]    root_r [RW];
  logic [TAG_W-1:0] tag_r  [RW];
  logic             vld_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [IN_W-1:0]  rad_prev;
    logic [RW+1:0]    rem_prev;
    logic [RW-1:0]    root_prev;
    logic [TAG_W-1:0] tag_prev;
    logic             vld_prev;
    logic [RW+1:0]    remx;
    logic [RW+1:0]    trial;
    logic             ge;
    logic [RW+1:0]    rem_nxt;
    logic [RW-1:0]    root_nxt;

    if (k == 0) begin : g_first
      assign rad_prev  = rad_i;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign tag_prev  = tag_i;
      assign vld_prev  = vld_i;
    end else begin : g_next
      assign rad_prev  = rad_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign tag_prev  = tag_r[k-1];
      assign vld_prev  = vld_r[k-1];
    end

    always_comb begin
      remx     = {rem_prev[RW-1:0], rad_prev[IN_W-1 -: 2]};
      trial    = {root_prev, 2'b01};
      ge       = (remx >= trial);
      rem_nxt  = ge ? (remx - trial) : remx;
      root_nxt = {root_prev[RW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_prev << 2;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        tag_r[k]  <= tag_prev;
      end
    end
  end

  assign vld_o  = vld_r[RW-1];
  assign root_o = root_r[RW-1];
  assign tag_o  = tag_r[RW-1];
endmodule
`default_nettype wire

>>> design/rmq_div.sv
// Pipelined restoring divider for the rounded quotient mag * 2^FRAC_BITS / (2 * root).
`timescale 1ns / 1ps
`default_nettype none
module rmq_div
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter int RW        = 16
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [MAG_W-1:0] mag_i,
  input  wire logic [RW-1:0]    root_i,
  output logic [Q_W-1:0]        q_o,
  output logic                  ovf_o
);
  localparam int ND  = MAG_W + FRAC_BITS + 1;
  localparam int DW  = RW + 1;
  localparam int XW  = (ND > DW + Q_W) ? ND : DW + Q_W;
  localparam int NST = Q_W + 2;

  logic [XW-1:0]  rem_r [NST];
  logic [DW-1:0]  d_r   [NST];
  logic [Q_W-1:0] q_r   [NST];
  logic           ovf_r [NST];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= (XW'(mag_i) << FRAC_BITS) + XW'(root_i);
      d_r[0]   <= {root_i, 1'b0};
      q_r[0]   <= '0;
      ovf_r[0] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[1] <= rem_r[0];
      d_r[1]   <= d_r[0];
      q_r[1]   <= '0;
      ovf_r[1] <= (rem_r[0] >= (XW'(d_r[0]) << Q_W));
    end
  end

  for (genvar s = 2; s < NST; s++) begin : g_bit
    localparam int BI = NST - 1 - s;
    logic [XW-1:0]  sh;
    logic           ge;
    logic [XW-1:0]  rem_nxt;
    logic [Q_W-1:0] q_nxt;

    always_comb begin
      sh      = XW'(d_r[s-1]) << BI;
      ge      = (rem_r[s-1] >= sh);
      rem_nxt = ge ? (rem_r[s-1] - sh) : rem_r[s-1];
      q_nxt   = q_r[s-1] | (Q_W'(ge) << BI);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        d_r[s]   <= d_r[s-1];
        q_r[s]   <= q_nxt;
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  assign q_o   = q_r[NST-1];
  assign ovf_o = ovf_r[NST-1];
endmodule
`default_nettype wire

>>> design/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
//
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_tvalid/in_tready  | in_tdata: nine Q2.14 matrix entries
// out_    | output    | out_tvalid/out_tready| out_tdata: quaternion, out_tuser: case, flag
//
// One matrix is taken per cycle while the skid register is empty. A matrix passes through
// the input register, the square root pipeline, the three parallel dividers and the output
// register; the root width RW is 16 for FRAC_BITS = 14. Reset clears all valid bits and
// the output and skid registers. A stall at the output fills a skid register and
// then freezes the whole pipeline; in_tready is low only while the skid is full.
`timescale 1ns / 1ps
`default_nettype none
`include "rotation_matrix_to_quaternion_macros.svh"
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // qx, qy, qz, qw
  output logic [2:0]        out_tuser   // branch[1:0], degenerate
);
  localparam int AW      = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int SQ_W    = ((AW - 1 + FRAC_BITS + 1) / 2) * 2;
  localparam int RW      = SQ_W / 2;
  localparam int CW      = RW + 16;
  localparam int DIV_LAT = Q_W + 2;
  localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

  logic adv;

  logic signed [15:0]   m [9];
  logic signed [17:0]   e [9];
  logic signed [16:0]   f [9];
  logic signed [17:0]   trace;
  logic signed [17:0]   dsel;
  logic signed [AW-1:0] arg;
  logic signed [16:0]   n [3];
  br_t                  br_nxt;
  side_t                side_nxt;
  logic [SQ_W-1:0]      rad_nxt;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = in_tdata[16*i +: 16];
      e[i] = 18'(m[i]);
      f[i] = 17'(m[i]);
    end
    trace = e[0] + e[4] + e[8];
    if (trace > 0) begin
      br_nxt = BR_TRACE;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      br_nxt = BR_X;
    end else if (m[4] > m[8]) begin
      br_nxt = BR_Y;
    end else begin
      br_nxt = BR_Z;
    end
    case (br_nxt)
      BR_TRACE: begin
        dsel = trace;
        n[0] = f[7] - f[5];
        n[1] = f[2] - f[6];
        n[2] = f[3] - f[1];
      end
      BR_X: begin
        dsel = e[0] - e[4] - e[8];
        n[0] = f[7] - f[5];
        n[1] = f[1] + f[3];
        n[2] = f[2] + f[6];
      end
      BR_Y: begin
        dsel = e[4] - e[0] - e[8];
        n[0] = f[2] - f[6];
        n[1] = f[1] + f[3];
        n[2] = f[5] + f[7];
      end
      default: begin
        dsel = e[8] - e[0] - e[4];
        n[0] = f[3] - f[1];
        n[1] = f[2] + f[6];
        n[2] = f[5] + f[7];
      end
    endcase
    arg            = ONE + AW'(dsel);
    side_nxt.br    = br_nxt;
    side_nxt.degen = arg[AW-1] || (arg == '0);
    for (int s = 0; s < 3; s++) begin
      side_nxt.neg[s] = n[s][16];
      side_nxt.mag[s] = n[s][16] ? 17'(-n[s]) : 17'(n[s]);
    end
    rad_nxt = side_nxt.degen ? '0 : (SQ_W'(arg[AW-2:0]) << FRAC_BITS);
  end

  logic            s1_vld_r;
  side_t           s1_side_r;
  logic [SQ_W-1:0] s1_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= side_nxt;
      s1_rad_r  <= rad_nxt;
    end
  end

  logic                     sq_vld;
  logic [RW-1:0]            sq_root;
  logic [$bits(side_t)-1:0] sq_tag;
  side_t                    sq_side;

  rmq_sqrt #(
    .IN_W  (SQ_W),
    .TAG_W ($bits(side_t))
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (s1_vld_r),
    .rad_i  (s1_rad_r),
    .tag_i  (s1_side_r),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .tag_o  (sq_tag)
  );

  assign sq_side = side_t'(sq_tag);

  logic [Q_W-1:0] dq   [3];
  logic           dovf [3];

  for (genvar s = 0; s < 3; s++) begin : g_div
    rmq_div #(
      .FRAC_BITS (FRAC_BITS),
      .RW        (RW)
    ) u_div (
      .clk    (clk),
      .en     (adv),
      .mag_i  (sq_side.mag[s]),
      .root_i (sq_root),
      .q_o    (dq[s]),
      .ovf_o  (dovf[s])
    );
  end

  logic [RW-1:0] root_half;
  post_t         post_nxt;

  always_comb begin
    root_half      = sq_root >> 1;
    post_nxt.br    = sq_side.br;
    post_nxt.degen = sq_side.degen;
    post_nxt.neg   = sq_side.neg;
    post_nxt.rootq = (CW'(root_half) > CW'(32767)) ? 16'h7FFF : 16'(CW'(root_half));
  end

  post_t post_r [DIV_LAT];
  logic  pv_r   [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_post
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[k] <= 1'b0;
      end else if (adv) begin
        pv_r[k] <= (k == 0) ? sq_vld : pv_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        post_r[k] <= (k == 0) ? post_nxt : post_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  function automatic logic [15:0] sat_q(input logic [Q_W-1:0] q, input logic ovf,
                                        input logic neg);
    logic [15:0] res;
    if (!neg) begin
      res = (ovf || q > Q_W'(32767)) ? 16'h7FFF : q[15:0];
    end else begin
      res = (ovf || q > Q_W'(32768)) ? 16'h8000 : 16'(-q);
    end
    return res;
  endfunction

  post_t       pe;
  logic        pe_vld;
  logic [15:0] sv [3];
  logic [15:0] qx, qy, qz, qw;
  logic [63:0] fin_data;
  logic [2:0]  fin_user;

  always_comb begin
    pe     = post_r[DIV_LAT-1];
    pe_vld = pv_r[DIV_LAT-1];
    for (int s = 0; s < 3; s++) begin
      sv[s] = sat_q(dq[s], dovf[s], pe.neg[s]);
    end
    case (pe.br)
      BR_TRACE: begin
        qx = sv[0]; qy = sv[1]; qz = sv[2]; qw = pe.rootq;
      end
      BR_X: begin
        qx = pe.rootq; qy = sv[1]; qz = sv[2]; qw = sv[0];
      end
      BR_Y: begin
        qx = sv[1]; qy = pe.rootq; qz = sv[2]; qw = sv[0];
      end
      default: begin
        qx = sv[1]; qy = sv[2]; qz = pe.rootq; qw = sv[0];
      end
    endcase
    fin_data = pe.degen ? 64'd0 : {qw, qz, qy, qx};
    fin_user = {pe.degen, pe.br};
  end

  logic        out_vld_r, out_vld_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  logic [63:0] skid_data_r, skid_data_nxt;
  logic [2:0]  skid_user_r, skid_user_nxt;
  logic        out_free;

  assign adv = !skid_vld_r;

  always_comb begin
    out_free      = !out_vld_r || out_tready;
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    skid_user_nxt = skid_user_r;
    if (skid_vld_r) begin
      if (out_free) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = skid_data_r;
        out_user_nxt = skid_user_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (pe_vld) begin
      if (out_free) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = fin_data;
        out_user_nxt = fin_user;
      end else begin
        skid_vld_nxt  = 1'b1;
        skid_data_nxt = fin_data;
        skid_user_nxt = fin_user;
      end
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      out_data_r  <= '0;
      out_user_r  <= '0;
      skid_vld_r  <= 1'b0;
      skid_data_r <= '0;
      skid_user_r <= '0;
    end else begin
      out_vld_r   <= out_vld_nxt;
      out_data_r  <= out_data_nxt;
      out_user_r  <= out_user_nxt;
      skid_vld_r  <= skid_vld_nxt;
      skid_data_r <= skid_data_nxt;
      skid_user_r <= skid_user_nxt;
    end
  end

  assign in_tready  = !skid_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `RMQ_ASSERT_IMPL(a_skid_needs_out, skid_vld_r, out_vld_r, "skid holds a request while output is empty")
  `RMQ_ASSERT_IMPL(a_trace_not_degen, out_vld_r && out_user_r[1:0] == BR_TRACE, !out_user_r[2], "degenerate flag set on positive trace")
  `RMQ_ASSERT_IMPL(a_degen_zero, out_vld_r && out_user_r[2], out_data_r == 64'd0, "degenerate request carries nonzero quaternion")
  `RMQ_ASSERT_ALWAYS(a_skid_fill, !($rose(skid_vld_r) && $past(out_tready)), "skid filled while output was being taken")
endmodule
`default_nettype wire

>>> tb/sv/tb_rotation_matrix_to_quaternion.sv
// Self-checking testbench for the rotation matrix to quaternion converter.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 37;
  localparam int N_RANDOM = 500;

  typedef struct packed {
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
    logic [15:0] qw;
    br_t         br;
    logic        degen;
  } quat_t;

  typedef struct {
    logic [8:0][15:0] m;
    bit               has_known;
    quat_t            known;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [2:0]   out_tuser;

  quat_t       quat_queue[$];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  stim_row_t   dir_rows[$];

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] frac_divide(longint num, longint unsigned r);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = ((mag << FRAC) + r) / (r << 1);
    if (q > 65536) q = 65536;
    return clamp16(num < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_t shepperd_quat(logic [8:0][15:0] raw);
    longint m[9];
    longint trace;
    longint arg;
    longint unsigned r;
    quat_t q;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(raw[i]));
    q = '0;
    trace = m[0] + m[4] + m[8];
    if (trace > 0) begin
      q.br = BR_TRACE;
      arg = (64'sd1 << FRAC) + trace;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      q.br = BR_X;
      arg = (64'sd1 << FRAC) + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      q.br = BR_Y;
      arg = (64'sd1 << FRAC) + m[4] - m[0] - m[8];
    end else begin
      q.br = BR_Z;
      arg = (64'sd1 << FRAC) + m[8] - m[0] - m[4];
    end
    if (arg <= 0) begin
      q.degen = 1'b1;
      return q;
    end
    r = int_sqrt(longint'(arg) << FRAC);
    if (r == 0) r = 1;
    case (q.br)
      BR_TRACE: begin
        q.qw = clamp16(longint'(r >> 1));
        q.qx = frac_divide(m[7] - m[5], r);
        q.qy = frac_divide(m[2] - m[6], r);
        q.qz = frac_divide(m[3] - m[1], r);
      end
      BR_X: begin
        q.qx = clamp16(longint'(r >> 1));
        q.qw = frac_divide(m[7] - m[5], r);
        q.qy = frac_divide(m[1] + m[3], r);
        q.qz = frac_divide(m[2] + m[6], r);
      end
      BR_Y: begin
        q.qy = clamp16(longint'(r >> 1));
        q.qw = frac_divide(m[2] - m[6], r);
        q.qx = frac_divide(m[1] + m[3], r);
        q.qz = frac_divide(m[5] + m[7], r);
      end
      default: begin
        q.qz = clamp16(longint'(r >> 1));
        q.qw = frac_divide(m[3] - m[1], r);
        q.qx = frac_divide(m[2] + m[6], r);
        q.qy = frac_divide(m[5] + m[7], r);
      end
    endcase
    return q;
  endfunction

  function automatic logic [8:0][15:0] pack_matrix(int a0, int a1, int a2, int a3, int a4,
                                                   int a5, int a6, int a7, int a8);
    logic [8:0][15:0] raw;
    raw[0] = a0[15:0]; raw[1] = a1[15:0]; raw[2] = a2[15:0];
    raw[3] = a3[15:0]; raw[4] = a4[15:0]; raw[5] = a5[15:0];
    raw[6] = a6[15:0]; raw[7] = a7[15:0]; raw[8] = a8[15:0];
    return raw;
  endfunction

  task automatic add_row(logic [8:0][15:0] raw, bit has_known, quat_t known);
    stim_row_t row;
    row.m = raw;
    row.has_known = has_known;
    row.known = known;
    dir_rows.push_back(row);
  endtask

  function automatic quat_t known_quat(int qx, int qy, int qz, int qw, br_t br, bit degen);
    quat_t q;
    q.qx = qx[15:0]; q.qy = qy[15:0]; q.qz = qz[15:0]; q.qw = qw[15:0];
    q.br = br; q.degen = degen;
    return q;
  endfunction

  task automatic send_matrix(logic [8:0][15:0] raw, quat_t expected);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= raw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    quat_queue.push_back(expected);
  endtask

  function automatic logic [8:0][15:0] random_matrix();
    logic [8:0][15:0] raw;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 3) raw[i] = 16'($urandom());
      else if (mode < 8) raw[i] = 16'($signed($urandom_range(32768)) - 16384);
      else raw[i] = $urandom_range(1) ? 16'h7fff : 16'h8000;
    end
    if (mode == 9) begin
      raw[0] = raw[4];
      if ($urandom_range(1)) raw[8] = raw[4];
    end
    return raw;
  endfunction

  always @(posedge clk) begin
    quat_t got;
    quat_t exp_q;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48],
             br_t'(out_tuser[1:0]), out_tuser[2]};
      if (quat_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_q = quat_queue.pop_front();
        if (got.qx !== exp_q.qx) begin
          $display("%0t: qx expected %h actual %h", $time, exp_q.qx, got.qx); errors++;
        end
        if (got.qy !== exp_q.qy) begin
          $display("%0t: qy expected %h actual %h", $time, exp_q.qy, got.qy); errors++;
        end
        if (got.qz !== exp_q.qz) begin
          $display("%0t: qz expected %h actual %h", $time, exp_q.qz, got.qz); errors++;
        end
        if (got.qw !== exp_q.qw) begin
          $display("%0t: qw expected %h actual %h", $time, exp_q.qw, got.qw); errors++;
        end
        if (got.br !== exp_q.br) begin
          $display("%0t: branch expected %0d actual %0d", $time, exp_q.br, got.br); errors++;
        end
        if (got.degen !== exp_q.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, exp_q.degen, got.degen);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    quat_t none;
    quat_t expected;
    none = '0;
    errors = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 63;
    // Identity, its negation, a half turn per axis and the extremes of the entries.
    add_row(pack_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1,
            known_quat(0, 0, 0, 16384, BR_TRACE, 0));
    add_row(pack_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 0, none);
    add_row(pack_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1,
            known_quat(16384, 0, 0, 0, BR_X, 0));
    add_row(pack_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1,
            known_quat(0, 16384, 0, 0, BR_Y, 0));
    add_row(pack_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1,
            known_quat(0, 0, 16384, 0, BR_Z, 0));
    add_row(pack_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(pack_matrix(0, -32768, 0, 32767, 0, 0, 0, 0, 0), 0, none);
    add_row(pack_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0,
            none);
    add_row(pack_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                        -32768), 0, none);
    add_row(pack_matrix(-32768, 0, 0, 0, 32767, 0, 0, 0, 32767), 0, none);
    add_row(pack_matrix(-100, 0, 0, 0, -20000, 0, 0, 0, -20000), 0, none);
    add_row(pack_matrix(-100, 32767, 0, -32768, -100, 0, 0, 0, -20000), 0, none);
    add_row(pack_matrix(-20000, 0, 32767, 0, -100, 32767, 32767, 32767, -100), 0, none);
    add_row(pack_matrix(-32768, 1, -1, 1, -32768, 1, -1, 1, 32767), 0, none);
    add_row(pack_matrix(-16384, 5, 7, 9, -16384, 11, 13, 15, -16384), 0, none);
    add_row(pack_matrix(10, 32767, -32768, -32768, -20, 32767, 32767, -32768, 9), 0, none);
    // Nonpositive trace cases that select the z and the y branch.
    add_row(pack_matrix(-1, 0, 0, 0, -32768, 0, 0, 0, 16000), 0, none);
    add_row(pack_matrix(0, 0, 0, 0, 0, 0, 0, 0, -16384), 0, none);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      expected = shepperd_quat(dir_rows[i].m);
      if (dir_rows[i].has_known && dir_rows[i].known !== expected)
        $display("%0t: row %0d expected %h actual %h", $time, i, dir_rows[i].known, expected);
      if (dir_rows[i].has_known) expected = dir_rows[i].known;
      send_matrix(dir_rows[i].m, expected);
    end
    in_tvalid <= 1'b0;
    // Hold off until the pipeline drains completely.
    while (quat_queue.size() != 0) @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 9 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        logic [8:0][15:0] raw;
        raw = random_matrix();
        send_matrix(raw, shepperd_quat(raw));
      end
    end
    in_tvalid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/rmq_pkg.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion.sv
tb/sv/tb_rotation_matrix_to_quaternion.sv
